>>> sv/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_O  = 8'h4F;
   localparam logic [7:0] CHAR_K  = 8'h4B;
   localparam logic [7:0] CMD_ONE_BYTE = 8'h41;
   localparam logic [7:0] CMD_NUMBER   = 8'h4E;
   localparam logic [7:0] CMD_CLEAR    = 8'h43;
   localparam logic [7:0] CMD_SET      = 8'h53;
   localparam logic [7:0] CMD_QUIT     = 8'h51;

   localparam logic [3:0] DIGIT_BLANK = 4'd10;
   localparam logic [3:0] DIGIT_RESET = 4'd5;

   localparam logic [7:0] SLICE_RESET = 8'd2;
   localparam logic [7:0] RING_RESET  = 8'b00000001;
   localparam logic [7:0] RING_TOP    = 8'h80;
   localparam logic [7:0] LEVEL_HIGH  = 8'hFF;
   localparam logic [7:0] LEVEL_LOW   = 8'h00;

   localparam int unsigned PROC_RIGHT_RING = 0;
   localparam int unsigned PROC_LEFT_RING  = 1;
   localparam int unsigned PROC_TOGGLE     = 2;

   localparam logic [1:0] BEAT_O  = 2'd0;
   localparam logic [1:0] BEAT_K  = 2'd1;
   localparam logic [1:0] BEAT_CR = 2'd2;
   localparam logic [1:0] BEAT_LF = 2'd3;

   typedef struct packed {
      logic [7:0] segments;
      logic [7:0] anode;
      logic [7:0] pattern;
      logic       run_valid;
      logic [2:0] run_process;
   } tick_result_type;

   typedef struct packed {
      logic       burst;
      logic [7:0] segments;
      logic [7:0] anode;
      logic [7:0] pattern;
      logic       run_valid;
      logic [2:0] run_process;
   } rsp_load_type;

   function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'h01;
         4'd1:    seg = 8'b01001111;
         4'd2:    seg = 8'b00010010;
         4'd3:    seg = 8'b00000110;
         4'd4:    seg = 8'h4C;
         4'd5:    seg = 8'h24;
         4'd6:    seg = 8'h20;
         4'd7:    seg = 8'h0F;
         4'd8:    seg = 8'h00;
         4'd9:    seg = 8'h04;
         default: seg = 8'b11111111;
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] ok_char(input logic [1:0] beat);
      logic [7:0] c;
      unique case (beat)
         BEAT_O:  c = CHAR_O;
         BEAT_K:  c = CHAR_K;
         BEAT_CR: c = CHAR_CR;
         default: c = CHAR_LF;
      endcase
      return c;
   endfunction

endpackage

>>> sv/scd_cmd.sv
`timescale 1ns / 1ps

module scd_cmd #(
   parameter int NUM_PROCESSES = 3,
   parameter int NUM_DIGITS    = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire_byte,
   input  logic [7:0]                     rx_byte,
   output logic                           ok_burst,
   output logic [NUM_DIGITS-1:0][3:0]     digits,
   output logic [NUM_PROCESSES-1:0]       enable_mask
);
   import scd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ONE,
      PH_DIGITS,
      PH_CR,
      PH_LF,
      PH_SET,
      PH_CLR
   } phase_type;

   phase_type                       phase_ff;
   logic [NUM_DIGITS-1:0][3:0]      digits_ff;
   logic [NUM_PROCESSES-1:0]        enable_ff;
   logic [NUM_PROCESSES-1:0]        enable_bit;
   logic [3:0]                      nibble;

   assign nibble = rx_byte[3:0];

   always_comb begin
      if (nibble >= 4'd1 && nibble <= 4'(NUM_PROCESSES)) begin
         enable_bit = NUM_PROCESSES'(1) << (nibble - 4'd1);
      end else begin
         enable_bit = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digits_ff <= {NUM_DIGITS{DIGIT_RESET}};
         enable_ff <= '0;
      end else if (fire_byte) begin
         unique case (phase_ff)
            PH_IDLE: begin
               priority if (rx_byte == CMD_ONE_BYTE) begin
                  phase_ff <= PH_ONE;
               end else if (rx_byte == CMD_NUMBER) begin
                  digits_ff <= {NUM_DIGITS{DIGIT_BLANK}};
                  phase_ff  <= PH_DIGITS;
               end else if (rx_byte == CMD_CLEAR) begin
                  digits_ff <= {NUM_DIGITS{DIGIT_BLANK}};
                  phase_ff  <= PH_CR;
               end else if (rx_byte == CMD_SET) begin
                  phase_ff <= PH_SET;
               end else if (rx_byte == CMD_QUIT) begin
                  phase_ff <= PH_CLR;
               end else begin
                  phase_ff <= PH_IDLE;
               end
            end
            PH_ONE:    phase_ff <= PH_CR;
            PH_DIGITS: begin
               if (rx_byte == CHAR_CR) begin
                  phase_ff <= PH_LF;
               end else begin
                  digits_ff <= {digits_ff[NUM_DIGITS-2:0], nibble};
               end
            end
            PH_CR:     phase_ff <= PH_LF;
            PH_LF:     phase_ff <= PH_IDLE;
            PH_SET: begin
               enable_ff <= enable_ff | enable_bit;
               phase_ff  <= PH_CR;
            end
            PH_CLR: begin
               enable_ff <= enable_ff & ~enable_bit;
               phase_ff  <= PH_CR;
            end
            default:   phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign ok_burst    = fire_byte && (phase_ff == PH_LF);
   assign digits      = digits_ff;
   assign enable_mask = enable_ff;

endmodule

>>> sv/scd_sched.sv
`timescale 1ns / 1ps

module scd_sched #(
   parameter int NUM_PROCESSES = 3,
   parameter int NUM_DIGITS    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire_tick,
   input  logic                        csr_write_enable,
   input  logic [7:0]                  csr_write_data,
   input  logic [NUM_PROCESSES-1:0]    enable_mask,
   input  logic [NUM_DIGITS-1:0][3:0]  digits,
   output scd_pkg::tick_result_type    result
);
   import scd_pkg::*;

   localparam int SW = $clog2(NUM_DIGITS);
   localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
   localparam int CW = PW + 1;

   logic [7:0]    slice_length_ff;
   logic [7:0]    slice_count_ff;
   logic [SW-1:0] scan_ff;
   logic [SW-1:0] scan_in;
   logic [PW-1:0] current_ff;
   logic [PW-1:0] pick;
   logic [CW-1:0] cand;
   logic [7:0]    right_ring_ff;
   logic [7:0]    left_ring_ff;
   logic          toggle_ff;
   logic [7:0]    pattern_ff;
   logic [7:0]    right_in;
   logic [7:0]    left_in;
   logic          toggle_in;
   logic [7:0]    pattern_in;
   logic          slice_end;
   logic          run;

   assign scan_in   = (scan_ff == SW'(NUM_DIGITS - 1)) ? '0 : scan_ff + SW'(1);
   assign slice_end = (slice_count_ff == slice_length_ff - 8'd1);
   assign run       = fire_tick && slice_end && (|enable_mask);

   always_comb begin
      pick = current_ff;
      cand = '0;
      for (int k = NUM_PROCESSES; k >= 1; k--) begin
         cand = {1'b0, current_ff} + CW'(k);
         if (cand >= CW'(NUM_PROCESSES)) begin
            cand = cand - CW'(NUM_PROCESSES);
         end
         if (enable_mask[cand[PW-1:0]]) begin
            pick = cand[PW-1:0];
         end
      end
   end

   assign right_in  = (right_ring_ff == RING_TOP) ? RING_RESET : {right_ring_ff[6:0], 1'b0};
   assign left_in   = (left_ring_ff == RING_RESET) ? RING_TOP : {1'b0, left_ring_ff[7:1]};
   assign toggle_in = ~toggle_ff;

   always_comb begin
      pattern_in = pattern_ff;
      if (run) begin
         priority if (32'(pick) == PROC_RIGHT_RING) begin
            pattern_in = right_in;
         end else if (32'(pick) == PROC_LEFT_RING) begin
            pattern_in = left_in;
         end else if (32'(pick) == PROC_TOGGLE) begin
            pattern_in = toggle_in ? LEVEL_HIGH : LEVEL_LOW;
         end else begin
            pattern_in = pattern_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_length_ff <= SLICE_RESET;
      end else if (csr_write_enable) begin
         slice_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_count_ff <= '0;
         scan_ff        <= SW'(NUM_DIGITS - 1);
         current_ff     <= '0;
         right_ring_ff  <= RING_RESET;
         left_ring_ff   <= RING_RESET;
         toggle_ff      <= 1'b0;
         pattern_ff     <= '0;
      end else if (fire_tick) begin
         scan_ff        <= scan_in;
         slice_count_ff <= slice_end ? 8'd0 : slice_count_ff + 8'd1;
         pattern_ff     <= pattern_in;
         if (run) begin
            current_ff <= pick;
            if (32'(pick) == PROC_RIGHT_RING) begin
               right_ring_ff <= right_in;
            end
            if (32'(pick) == PROC_LEFT_RING) begin
               left_ring_ff <= left_in;
            end
            if (32'(pick) == PROC_TOGGLE) begin
               toggle_ff <= toggle_in;
            end
         end
      end
   end

   always_comb begin
      result.segments    = seg_lookup(digits[scan_in]);
      result.anode       = 8'b00000001 << scan_in;
      result.pattern     = pattern_in;
      result.run_valid   = run;
      result.run_process = run ? 3'(pick) : 3'd0;
   end

endmodule

>>> sv/scd_out.sv
`timescale 1ns / 1ps

module scd_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  scd_pkg::rsp_load_type load_data,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_tx_valid,
   output logic [7:0]            rsp_tx_byte,
   output logic                  rsp_last,
   output logic [7:0]            rsp_segments,
   output logic [7:0]            rsp_anode,
   output logic [7:0]            rsp_pattern_out,
   output logic                  rsp_run_valid,
   output logic [2:0]            rsp_run_process
);
   import scd_pkg::*;

   logic         valid_ff;
   logic [1:0]   beat_ff;
   rsp_load_type data_ff;
   logic         last;

   assign last     = !data_ff.burst || (beat_ff == BEAT_LF);
   assign out_free = !valid_ff || (rsp_ready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= BEAT_O;
      end else if (load) begin
         valid_ff <= 1'b1;
         beat_ff  <= BEAT_O;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_ff <= 1'b0;
            beat_ff  <= BEAT_O;
         end else begin
            beat_ff <= beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_tx_valid    = data_ff.burst;
   assign rsp_tx_byte     = data_ff.burst ? ok_char(beat_ff) : 8'd0;
   assign rsp_last        = last;
   assign rsp_segments    = data_ff.segments;
   assign rsp_anode       = data_ff.anode;
   assign rsp_pattern_out = data_ff.pattern;
   assign rsp_run_valid   = data_ff.run_valid;
   assign rsp_run_process = data_ff.run_process;

`ifndef NO_ASSERTIONS
   a_beat_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.burst && rsp_ready && (beat_ff != BEAT_LF)
      |=> valid_ff && data_ff.burst && (beat_ff == $past(beat_ff) + 2'd1))
      else $error("reply beat did not advance");
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.burst |-> (beat_ff == BEAT_O) && last)
      else $error("single result carries a beat count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free)
      else $error("result register loaded while occupied");
`endif

endmodule

>>> sv/serial_command_display_scheduler_core.sv
`timescale 1ns / 1ps
// Channel  Handshake               Payload
// req      req_valid / req_ready   req_action, req_rx_byte
// rsp      rsp_valid / rsp_ready   rsp_tx_valid .. rsp_run_process
// csr      csr_write_enable        csr_write_data (slice length)
//
// A transaction goes input register -> command/scheduler logic -> result register:
// one transaction per cycle sustained while rsp is ready and no reply burst is out.
// A command's LF-phase byte (any value) yields four results (O K CR LF) from the
// result register's beat counter; the next load waits for the last. Reset is synchronous;
// no clearing pass. A stalled rsp holds the result register and a full input one.

module serial_command_display_scheduler_core #(
   parameter int NUM_PROCESSES = 3,
   parameter int NUM_DIGITS    = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic [7:0] rsp_segments,
   output logic [7:0] rsp_anode,
   output logic [7:0] rsp_pattern_out,
   output logic       rsp_run_valid,
   output logic [2:0] rsp_run_process,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   import scd_pkg::*;

   logic                          in_valid_ff;
   logic                          in_action_ff;
   logic [7:0]                    in_byte_ff;
   logic                          out_free;
   logic                          fire;
   logic                          fire_tick;
   logic                          fire_byte;
   logic                          ok_burst;
   logic [NUM_DIGITS-1:0][3:0]    digits;
   logic [NUM_PROCESSES-1:0]      enable_mask;
   tick_result_type               tick_res;
   rsp_load_type                  load_data;

   assign fire      = in_valid_ff && out_free;
   assign fire_tick = fire && (in_action_ff == ACTION_TICK);
   assign fire_byte = fire && (in_action_ff == ACTION_BYTE);
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   scd_cmd #(
      .NUM_PROCESSES(NUM_PROCESSES),
      .NUM_DIGITS   (NUM_DIGITS)
   ) u_cmd (
      .clock      (clock),
      .reset      (reset),
      .fire_byte  (fire_byte),
      .rx_byte    (in_byte_ff),
      .ok_burst   (ok_burst),
      .digits     (digits),
      .enable_mask(enable_mask)
   );

   scd_sched #(
      .NUM_PROCESSES(NUM_PROCESSES),
      .NUM_DIGITS   (NUM_DIGITS)
   ) u_sched (
      .clock           (clock),
      .reset           (reset),
      .fire_tick       (fire_tick),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .enable_mask     (enable_mask),
      .digits          (digits),
      .result          (tick_res)
   );

   always_comb begin
      load_data.burst   = ok_burst;
      load_data.pattern = tick_res.pattern;
      if (in_action_ff == ACTION_TICK) begin
         load_data.segments    = tick_res.segments;
         load_data.anode       = tick_res.anode;
         load_data.run_valid   = tick_res.run_valid;
         load_data.run_process = tick_res.run_process;
      end else begin
         load_data.segments    = 8'd0;
         load_data.anode       = 8'd0;
         load_data.run_valid   = 1'b0;
         load_data.run_process = 3'd0;
      end
   end

   scd_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (fire),
      .load_data      (load_data),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_segments   (rsp_segments),
      .rsp_anode      (rsp_anode),
      .rsp_pattern_out(rsp_pattern_out),
      .rsp_run_valid  (rsp_run_valid),
      .rsp_run_process(rsp_run_process)
   );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import scd_pkg::*;

   localparam int NUM_PROCESSES = 3;
   localparam int NUM_DIGITS    = 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 120;
   localparam int DIRECTED_ROWS = 27;
   localparam int ITEMS_PER_PHASE = 32;
   localparam int DRAIN_CYCLES  = 6;

   localparam logic [15:0][7:0] SEG_CODES = {
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'h00,
      8'h0F, 8'h20, 8'h24, 8'h4C, 8'h06, 8'h12, 8'h4F, 8'h01
   };

   typedef enum logic [2:0] {
      CP_IDLE,
      CP_ONE_BYTE,
      CP_DIGITS,
      CP_WAIT_CR,
      CP_WAIT_LF,
      CP_SET,
      CP_CLEAR
   } command_phase_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       last;
      logic [7:0] segments;
      logic [7:0] anode;
      logic [7:0] pattern_out;
      logic       run_valid;
      logic [2:0] run_process;
   } display_result_type;

   typedef struct {
      logic               act;
      logic [7:0]         data;
      bit                 typed;
      display_result_type res;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_action = ACTION_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last;
   logic [7:0] rsp_segments;
   logic [7:0] rsp_anode;
   logic [7:0] rsp_pattern_out;
   logic       rsp_run_valid;
   logic [2:0] rsp_run_process;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   // scheduler state as seen by the predictor
   command_phase_type        phase;
   logic [3:0]               digits [NUM_DIGITS];
   logic [2:0]               scan_pos;
   logic [7:0]               slice_count;
   logic [7:0]               slice_length;
   logic [2:0]               current_process;
   logic [NUM_PROCESSES-1:0] enable_mask;
   logic [7:0]               right_ring;
   logic [7:0]               left_ring;
   logic                     toggle_level;
   logic [7:0]               pattern_reg;

   display_result_type awaited_results [$];
   stim_row_type       directed [DIRECTED_ROWS];
   int unsigned        mismatches = 0;
   int unsigned        cycle_count = 0;
   int unsigned        sent_count = 0;
   int unsigned        burst_left = 0;
   int unsigned        hold_left = 0;
   int unsigned        rx_cycle = 0;
   bit                 hold_start = 1'b0;

   serial_command_display_scheduler_core #(
      .NUM_PROCESSES(NUM_PROCESSES),
      .NUM_DIGITS   (NUM_DIGITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_valid    (rsp_tx_valid),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_segments    (rsp_segments),
      .rsp_anode       (rsp_anode),
      .rsp_pattern_out (rsp_pattern_out),
      .rsp_run_valid   (rsp_run_valid),
      .rsp_run_process (rsp_run_process),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void reset_scheduler_state();
      phase = CP_IDLE;
      foreach (digits[i]) digits[i] = DIGIT_RESET;
      scan_pos = 3'(NUM_DIGITS - 1);
      slice_count = 8'd0;
      slice_length = SLICE_RESET;
      current_process = 3'd0;
      enable_mask = '0;
      right_ring = RING_RESET;
      left_ring = RING_RESET;
      toggle_level = 1'b0;
      pattern_reg = LEVEL_LOW;
   endfunction

   function automatic logic [NUM_PROCESSES-1:0] enable_select(input logic [7:0] b);
      logic [NUM_PROCESSES-1:0] sel;
      sel = '0;
      if (b[3:0] >= 4'd1 && b[3:0] <= 4'(NUM_PROCESSES)) sel[b[3:0] - 4'd1] = 1'b1;
      return sel;
   endfunction

   function automatic void step_pattern(input logic [2:0] p);
      if (p == PROC_RIGHT_RING) begin
         right_ring = (right_ring == RING_TOP) ? RING_RESET : right_ring << 1;
         pattern_reg = right_ring;
      end else if (p == PROC_LEFT_RING) begin
         left_ring = (left_ring == RING_RESET) ? RING_TOP : left_ring >> 1;
         pattern_reg = left_ring;
      end else if (p == PROC_TOGGLE) begin
         toggle_level = ~toggle_level;
         pattern_reg = toggle_level ? LEVEL_HIGH : LEVEL_LOW;
      end
   endfunction

   function automatic void predict_scheduler_results(input logic act, input logic [7:0] b);
      display_result_type r;
      logic [7:0]         slice_end;
      logic [2:0]         p;
      bit                 found;
      r = '0;
      r.last = 1'b1;
      if (act == ACTION_TICK) begin
         scan_pos = (scan_pos == 3'(NUM_DIGITS - 1)) ? 3'd0 : scan_pos + 3'd1;
         r.segments = SEG_CODES[digits[scan_pos]];
         r.anode = 8'd1 << scan_pos;
         slice_end = slice_length - 8'd1;
         if (slice_count == slice_end) begin
            slice_count = 8'd0;
            if (enable_mask != '0) begin
               p = current_process;
               found = 1'b0;
               for (int k = 0; k < NUM_PROCESSES && !found; k++) begin
                  p = (int'(p) + 1 >= NUM_PROCESSES) ? 3'd0 : p + 3'd1;
                  found = enable_mask[p];
               end
               current_process = p;
               step_pattern(p);
               r.run_valid = 1'b1;
               r.run_process = p;
            end
         end else begin
            slice_count = slice_count + 8'd1;
         end
         r.pattern_out = pattern_reg;
         awaited_results.push_back(r);
         return;
      end
      r.pattern_out = pattern_reg;
      case (phase)
         CP_IDLE: begin
            if (b == CMD_ONE_BYTE) begin
               phase = CP_ONE_BYTE;
            end else if (b == CMD_NUMBER) begin
               foreach (digits[i]) digits[i] = DIGIT_BLANK;
               phase = CP_DIGITS;
            end else if (b == CMD_CLEAR) begin
               foreach (digits[i]) digits[i] = DIGIT_BLANK;
               phase = CP_WAIT_CR;
            end else if (b == CMD_SET) begin
               phase = CP_SET;
            end else if (b == CMD_QUIT) begin
               phase = CP_CLEAR;
            end
         end
         CP_ONE_BYTE: phase = CP_WAIT_CR;
         CP_DIGITS: begin
            if (b == CHAR_CR) begin
               phase = CP_WAIT_LF;
            end else begin
               for (int i = NUM_DIGITS - 1; i > 0; i--) digits[i] = digits[i-1];
               digits[0] = b[3:0];
            end
         end
         CP_WAIT_CR: phase = CP_WAIT_LF;
         CP_WAIT_LF: begin
            phase = CP_IDLE;
            r.tx_valid = 1'b1;
            r.last = 1'b0;
            r.tx_byte = CHAR_O;
            awaited_results.push_back(r);
            r.tx_byte = CHAR_K;
            awaited_results.push_back(r);
            r.tx_byte = CHAR_CR;
            awaited_results.push_back(r);
            r.tx_byte = CHAR_LF;
            r.last = 1'b1;
         end
         CP_SET: begin
            enable_mask = enable_mask | enable_select(b);
            phase = CP_WAIT_CR;
         end
         CP_CLEAR: begin
            enable_mask = enable_mask & ~enable_select(b);
            phase = CP_WAIT_CR;
         end
         default: phase = CP_IDLE;
      endcase
      awaited_results.push_back(r);
   endfunction

   function automatic stim_row_type stim_row(input logic act, input logic [7:0] data,
                                             input bit typed = 1'b0,
                                             input logic [7:0] seg = 8'h00,
                                             input logic [7:0] an = 8'h00);
      stim_row_type s;
      s.act = act;
      s.data = data;
      s.typed = typed;
      s.res = '0;
      s.res.last = 1'b1;
      s.res.segments = seg;
      s.res.anode = an;
      return s;
   endfunction

   task automatic send_transaction(input logic act, input logic [7:0] b,
                                   input bit typed = 1'b0,
                                   input display_result_type typed_res = '0);
      int unsigned gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_scheduler_results(act, b);
      if (typed) begin
         void'(awaited_results.pop_back());
         awaited_results.push_back(typed_res);
      end
      sent_count++;
   endtask

   task automatic send_tick();
      send_transaction(ACTION_TICK, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 5) == 0) send_tick();
      send_transaction(ACTION_BYTE, b);
   endtask

   task automatic send_line_end();
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : CHAR_CR);
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : CHAR_LF);
   endtask

   task automatic send_enable_digit();
      send_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(8'h30 + $urandom_range(1, 3)));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slice_length(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      slice_length = value;
   endtask

   task automatic run_random_phase(input int unsigned n_items);
      int unsigned target;
      int unsigned pick;
      int unsigned n;
      target = sent_count + n_items;
      while (sent_count < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            n = $urandom_range(1, 8);
            repeat (n) send_tick();
         end else if (pick < 50) begin
            send_byte(CMD_NUMBER);
            n = $urandom_range(0, 10);
            repeat (n) send_byte(8'($urandom));
            send_line_end();
         end else if (pick < 60) begin
            send_byte(CMD_CLEAR);
            send_line_end();
         end else if (pick < 68) begin
            send_byte(CMD_ONE_BYTE);
            send_byte(8'($urandom));
            send_line_end();
         end else if (pick < 82) begin
            send_byte(CMD_SET);
            send_enable_digit();
            send_line_end();
         end else if (pick < 92) begin
            send_byte(CMD_QUIT);
            send_enable_digit();
            send_line_end();
         end else begin
            send_byte(8'($urandom));
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_start) begin
         hold_left = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_cycle[8:7])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
         endcase
      end
      rx_cycle++;
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %02h, got %02h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      display_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("result transaction with none expected");
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_tx_valid));
            check_field("tx_byte", want.tx_byte, rsp_tx_byte);
            check_field("last", 8'(want.last), 8'(rsp_last));
            check_field("segments", want.segments, rsp_segments);
            check_field("anode", want.anode, rsp_anode);
            check_field("pattern_out", want.pattern_out, rsp_pattern_out);
            check_field("run_valid", 8'(want.run_valid), 8'(rsp_run_valid));
            check_field("run_process", 8'(want.run_process), 8'(rsp_run_process));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [7:0] slice_settings [7];
      slice_settings = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd1, 8'($urandom_range(2, 6)), 8'd4};
      directed = '{
         stim_row(ACTION_TICK, 8'h00, 1'b1, 8'h24, 8'h01),
         stim_row(ACTION_TICK, 8'hFF, 1'b1, 8'h24, 8'h02),
         stim_row(ACTION_BYTE, 8'h00, 1'b1),
         stim_row(ACTION_BYTE, 8'hFF, 1'b1),
         stim_row(ACTION_BYTE, CMD_NUMBER),
         stim_row(ACTION_BYTE, 8'h30),
         stim_row(ACTION_BYTE, 8'h3F),
         stim_row(ACTION_BYTE, CHAR_CR),
         stim_row(ACTION_BYTE, 8'h00),
         stim_row(ACTION_TICK, 8'h00),
         stim_row(ACTION_BYTE, CMD_SET),
         stim_row(ACTION_BYTE, 8'h32),
         stim_row(ACTION_BYTE, CHAR_CR),
         stim_row(ACTION_BYTE, CHAR_LF),
         stim_row(ACTION_TICK, 8'h00),
         stim_row(ACTION_BYTE, CMD_QUIT),
         stim_row(ACTION_BYTE, 8'h90),
         stim_row(ACTION_BYTE, CHAR_CR),
         stim_row(ACTION_BYTE, CHAR_LF),
         stim_row(ACTION_BYTE, CMD_ONE_BYTE),
         stim_row(ACTION_BYTE, 8'hFF),
         stim_row(ACTION_BYTE, CHAR_CR),
         stim_row(ACTION_BYTE, CHAR_LF),
         stim_row(ACTION_BYTE, CMD_CLEAR),
         stim_row(ACTION_BYTE, 8'h5A),
         stim_row(ACTION_BYTE, CHAR_CR),
         stim_row(ACTION_BYTE, CHAR_LF)
      };
      reset_scheduler_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_transaction(directed[i].act, directed[i].data, directed[i].typed,
                          directed[i].res);
      end

      foreach (slice_settings[i]) begin
         drain_results();
         write_slice_length(slice_settings[i]);
         if (i == 0) begin
            // hold the result side off while a long burst keeps coming
            hold_start = 1'b1;
            burst_left = 60;
         end
         run_random_phase(ITEMS_PER_PHASE);
      end

      drain_results();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
